>>> hdl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Empty under synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/ttib_pkg.sv
// ============================================================================
// ttib_pkg
// Types and constants of the streaming text-to-integer parser.
// ============================================================================
package ttib_pkg;

    // default sizing
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_LENGTH_DEF  = 4096;

    // fixed result field widths
    localparam int VALUE_OUT_W = 32;
    localparam int OFFSET_W    = 13;
    localparam int BASE_W      = 6;
    localparam int DIGIT_W     = 6;
    localparam int CH_W        = 8;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
    localparam logic [BASE_W-1:0]   BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0]   BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0]   BASE_ONE   = 6'd1;
    localparam logic [BASE_W-1:0]   BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0]   BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0]   BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0]   BASE_HEX   = 6'd16;

    // character codes
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] LETTER_BIAS = 8'd10;

    // parse phase
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_START,
        PH_ZERO,
        PH_HEX,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    // decoded byte
    typedef struct packed {
        logic               is_space;
        logic               is_sign;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               is_alnum;
        logic [DIGIT_W-1:0] digit;
    } t_char;

    // one result item
    typedef struct packed {
        logic                   any_digits;
        logic [OFFSET_W-1:0]    end_offset;
        logic [VALUE_OUT_W-1:0] value;
    } t_result;

endpackage

>>> hdl/ttib_decode.sv
// ============================================================================
// ttib_decode
// Classifies one string byte: white space, sign, prefix letters, digit value.
// ============================================================================
module ttib_decode
    import ttib_pkg::*;
(
    input  logic [CH_W-1:0] i_ch,
    output t_char           o_char
);

    logic is_num;
    logic is_low;
    logic is_up;
    logic [CH_W-1:0] dval;

    // character ranges
    assign is_num = (i_ch >= CH_0)  && (i_ch <= CH_9);
    assign is_low = (i_ch >= CH_LA) && (i_ch <= CH_LZ);
    assign is_up  = (i_ch >= CH_UA) && (i_ch <= CH_UZ);

    // digit value, letters either case from ten up
    always_comb begin
        if (is_num) begin
            dval = i_ch - CH_0;
        end else if (is_low) begin
            dval = i_ch - CH_LA + LETTER_BIAS;
        end else begin
            dval = i_ch - CH_UA + LETTER_BIAS;
        end
    end

    always_comb begin
        o_char.is_space = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
        o_char.is_sign  = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
        o_char.is_minus = (i_ch == CH_MINUS);
        o_char.is_zero  = (i_ch == CH_0);
        o_char.is_x     = (i_ch == CH_LX) || (i_ch == CH_UX);
        o_char.is_alnum = is_num || is_low || is_up;
        o_char.digit    = dval[DIGIT_W-1:0];
    end

endmodule

>>> hdl/ttib_parse.sv
// ============================================================================
// ttib_parse
// Parse state and digit accumulator; one byte per step, result on last byte.
// ============================================================================
module ttib_parse
    import ttib_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_last,
    input  t_char             i_char,
    input  logic [BASE_W-1:0] i_base,
    output t_result           o_result
);

    localparam int PW = $clog2(MAX_LENGTH + 1);
    localparam int MW = VALUE_WIDTH + BASE_W;
    localparam int CW = (PW > OFFSET_W) ? PW : OFFSET_W;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_LENGTH);

    t_phase                 r_phase, n_phase;
    logic                   r_neg, n_neg;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [BASE_W-1:0]      r_ab, n_ab;
    logic [PW-1:0]          r_pos, n_pos;
    logic                   r_seen, n_seen;
    logic [PW-1:0]          r_stop, n_stop;

    logic              base_bad;
    logic              auto_base;
    logic              begin_num;
    logic              zero_pref;
    logic [BASE_W-1:0] begin_base;
    logic [BASE_W-1:0] tb;
    logic              digit_ok;
    logic              take;
    logic [MW-1:0]     mac;

    // base checks on the register value
    assign auto_base  = (i_base == BASE_AUTO);
    assign base_bad   = (i_base == BASE_ONE) || (i_base > BASE_MAX);
    assign begin_base = auto_base ? BASE_DEC : i_base;

    // first byte of the number itself
    assign begin_num = ((r_phase == PH_SPACE) && !i_char.is_space && !i_char.is_sign)
                     || (r_phase == PH_START);
    assign zero_pref = begin_num && !base_bad && i_char.is_zero
                     && (auto_base || (i_base == BASE_HEX));

    // digit test against the base in force
    assign tb       = begin_num ? begin_base : r_ab;
    assign digit_ok = i_char.is_alnum && (i_char.digit < tb);
    assign take     = digit_ok && (
                          (begin_num && !base_bad && !zero_pref)
                       || ((r_phase == PH_ZERO) && !i_char.is_x)
                       || (r_phase == PH_HEX)
                       || (r_phase == PH_DIGITS));

    // multiply-add, wraps at VALUE_WIDTH
    assign mac = MW'(r_acc) * MW'(tb) + MW'(i_char.digit);

    // saturating byte position
    assign n_pos = (r_pos < POS_MAX) ? r_pos + PW'(1) : POS_MAX;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SPACE: begin
                if (i_char.is_space) begin
                    n_phase = PH_SPACE;
                end else if (i_char.is_sign) begin
                    n_phase = PH_START;
                end else if (base_bad) begin
                    n_phase = PH_DONE;
                end else if (zero_pref) begin
                    n_phase = PH_ZERO;
                end else begin
                    n_phase = digit_ok ? PH_DIGITS : PH_DONE;
                end
            end
            PH_START: begin
                if (base_bad) begin
                    n_phase = PH_DONE;
                end else if (zero_pref) begin
                    n_phase = PH_ZERO;
                end else begin
                    n_phase = digit_ok ? PH_DIGITS : PH_DONE;
                end
            end
            PH_ZERO: begin
                if (i_char.is_x) begin
                    n_phase = PH_HEX;
                end else begin
                    n_phase = digit_ok ? PH_DIGITS : PH_DONE;
                end
            end
            PH_HEX, PH_DIGITS: begin
                n_phase = digit_ok ? PH_DIGITS : PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // datapath updates
    always_comb begin
        n_neg  = r_neg;
        n_acc  = r_acc;
        n_ab   = r_ab;
        n_seen = r_seen;
        n_stop = r_stop;
        if ((r_phase == PH_SPACE) && i_char.is_sign) begin
            n_neg = i_char.is_minus;
        end
        if (begin_num && !base_bad) begin
            if (zero_pref) begin
                n_ab = auto_base ? BASE_OCT : BASE_HEX;
            end else begin
                n_ab = begin_base;
            end
        end
        if ((r_phase == PH_ZERO) && i_char.is_x) begin
            n_ab = BASE_HEX;
        end
        if (zero_pref) begin
            n_acc  = '0;
            n_seen = 1'b1;
            n_stop = n_pos;
        end else if (take) begin
            n_acc  = mac[VALUE_WIDTH-1:0];
            n_seen = 1'b1;
            n_stop = n_pos;
        end
    end

    // state registers, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_ab    <= '0;
            r_pos   <= '0;
            r_seen  <= 1'b0;
            r_stop  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_ab    <= n_ab;
            r_pos   <= n_pos;
            r_seen  <= n_seen;
            r_stop  <= n_stop;
        end
    end

    // result from the state after this byte
    logic signed [VALUE_WIDTH-1:0] sval;
    logic [CW-1:0]                 stop_w;

    assign sval   = n_neg ? (~n_acc + VALUE_WIDTH'(1)) : n_acc;
    assign stop_w = CW'(n_stop);

    always_comb begin
        o_result.any_digits = n_seen;
        if (n_seen) begin
            o_result.value      = VALUE_OUT_W'(sval);
            o_result.end_offset = (stop_w > CW'(OFFSET_MAX)) ? OFFSET_MAX
                                                             : stop_w[OFFSET_W-1:0];
        end else begin
            o_result.value      = '0;
            o_result.end_offset = '0;
        end
    end

endmodule

>>> hdl/text_to_integer_with_base_unit.sv
// ============================================================================
// text_to_integer_with_base_unit
// A byte taken into the input register is parsed as it steps on; a last byte
//   stalls there while a result waits; its result goes to the result register.
// Throughput: one byte per cycle unless stalled; single multiply-add by base.
// Reset: synchronous, active low; parser idle, no result pending, base 10.
// ============================================================================
`include "assert_macros.svh"

module text_to_integer_with_base_unit
    import ttib_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BASE_W-1:0] i_cfg_data,    // number_base
    // byte stream in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // [7:0] ch
    input  logic              s_axis_tlast,  // last
    // result stream out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata   // [31:0] value, [44:32] end_offset,
                                             // [45] any_digits, [47:46] zero
);

    logic [BASE_W-1:0] r_base;
    logic              r_in_valid;
    logic [CH_W-1:0]   r_in_ch;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    logic              step;
    t_char             dec;
    t_result           res;

    // base register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    // a byte moves on unless its result would overwrite a waiting one
    assign step          = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch   <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    ttib_decode u_decode (
        .i_ch   (r_in_ch),
        .o_char (dec)
    );

    ttib_parse #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_last   (r_in_last),
        .i_char   (dec),
        .i_base   (r_base),
        .o_result (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.any_digits, r_out.end_offset, r_out.value};

    // checks
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, step && r_in_last, r_out_valid)
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, step && r_in_last && r_out_valid && !m_axis_tready)
    `ASSERT_ALWAYS(a_empty_is_zero, i_clk, i_rst_n, !r_out_valid || r_out.any_digits || (r_out.value == '0 && r_out.end_offset == '0))

endmodule
